/* design/aesc_pkg.sv */
// Package for the acyclic edge store: field widths, command kinds and status codes.
// No dependencies; imported by the top-level core of the block.
`default_nettype none
package aesc_pkg;

  localparam int KIND_W   = 2;
  localparam int WORD_W   = 7;
  localparam int REL_W    = 6;
  localparam int STATUS_W = 2;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [REL_W-1:0]    rel_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam kind_t KIND_INSERT = 2'd0;
  localparam kind_t KIND_REMOVE = 2'd1;
  localparam kind_t KIND_CHANGE = 2'd2;
  localparam kind_t KIND_CLEAR  = 2'd3;

  localparam status_t ST_DONE    = 2'd0;
  localparam status_t ST_REFUSED = 2'd1;
  localparam status_t ST_NO_EDGE = 2'd2;
  localparam status_t ST_RANGE   = 2'd3;

  localparam word_t WORD_COUNT_RST = 7'd64;

endpackage
`default_nettype wire

/* design/aesc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module aesc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* design/aesc_adj.sv */
// Adjacency row store: one RAM row per vertex plus per-row valid bits for instant clear.
// Depends on aesc_ram.
`default_nettype none
module aesc_adj #(
  parameter int MAX_WORDS = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         clr_all,
  input  wire logic                         rd_en,
  input  wire logic [$clog2(MAX_WORDS)-1:0] rd_addr,
  output logic      [MAX_WORDS-1:0]         rd_row,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(MAX_WORDS)-1:0] wr_addr,
  input  wire logic [MAX_WORDS-1:0]         wr_row
);

  localparam int VW = $clog2(MAX_WORDS);

  logic [MAX_WORDS-1:0] valid_r, valid_nxt;
  logic [VW-1:0]        rd_addr_r;
  logic [MAX_WORDS-1:0] ram_q;

  aesc_ram #(.WIDTH(MAX_WORDS), .DEPTH(MAX_WORDS)) u_rows (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_row),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  always_comb begin
    valid_nxt = valid_r;
    if (clr_all) begin
      valid_nxt = '0;
    end else if (wr_en) begin
      valid_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (rd_en) begin
      rd_addr_r <= rd_addr;
    end
  end

  // never-written rows read as empty
  assign rd_row = valid_r[rd_addr_r] ? ram_q : '0;

endmodule
`default_nettype wire

/* design/acyclic_edge_store_with_cycle_check_core.sv */
// Top level of the acyclic edge store: command FSM, reachability search, label store.
// Depends on aesc_pkg, aesc_adj and aesc_ram.
//
//  channel | ports                                        | transfer when
//  --------+----------------------------------------------+----------------------
//  input   | in_kind in_from_word in_to_word in_relation  | start & !busy
//  result  | out_status                                   | out_valid (one cycle)
//  config  | cfg_wdata                                    | cfg_we
//
// Clear and out-of-range commands answer straight from S_IDLE. Remove/change and
// refused inserts without search read one adjacency row (S_ROWF). Insert with
// search then reads one adjacency row per vertex visited in S_SEARCH, each vertex
// at most once, through the single read port of the adjacency row RAM. Reset (rst_n
// low, synchronous) empties the graph at once and sets word_count to 64. The result strobe cannot be stalled.
`default_nettype none
module acyclic_edge_store_with_cycle_check_core #(
  parameter int MAX_WORDS      = 64,
  parameter int RELATION_COUNT = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire aesc_pkg::kind_t  in_kind,
  input  wire aesc_pkg::word_t  in_from_word,
  input  wire aesc_pkg::word_t  in_to_word,
  input  wire aesc_pkg::rel_t   in_relation,
  output logic                  out_valid,
  output aesc_pkg::status_t     out_status,
  input  wire logic             cfg_we,
  input  wire aesc_pkg::word_t  cfg_wdata
);
  import aesc_pkg::*;

  localparam int VW = $clog2(MAX_WORDS);
  localparam int LW = $clog2(RELATION_COUNT);
  localparam int MW = MAX_WORDS;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_ROWF   = 3'b010,
    S_SEARCH = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  word_t           word_count_r;
  kind_t           kind_r, kind_nxt;
  logic [VW-1:0]   f_r, f_nxt, t_r, t_nxt;
  logic [LW-1:0]   lab_r, lab_nxt;
  logic [MW-1:0]   row_f_r, row_f_nxt;
  logic [MW-1:0]   reached_r, reached_nxt;
  logic [MW-1:0]   visited_r, visited_nxt;
  logic            rd_pend_r, rd_pend_nxt;
  logic            out_valid_r, out_valid_nxt;
  status_t         out_status_r, out_status_nxt;

  logic            adj_clr, adj_rd_en, adj_wr_en;
  logic [VW-1:0]   adj_rd_addr, adj_wr_addr;
  logic [MW-1:0]   adj_rd_row, adj_wr_row;
  logic            lab_we;

  logic [8:0]      n_words;
  logic            in_ok;
  logic [MW-1:0]   reach_now, pend, t_bit;
  logic [VW-1:0]   pick;

  aesc_adj #(.MAX_WORDS(MAX_WORDS)) u_adj (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr_all (adj_clr),
    .rd_en   (adj_rd_en),
    .rd_addr (adj_rd_addr),
    .rd_row  (adj_rd_row),
    .wr_en   (adj_wr_en),
    .wr_addr (adj_wr_addr),
    .wr_row  (adj_wr_row)
  );

  aesc_ram #(.WIDTH(LW), .DEPTH(1 << (2 * VW))) u_labels (
    .clk     (clk),
    .wr_en   (lab_we),
    .wr_addr ({f_r, t_r}),
    .wr_data (lab_r),
    .rd_en   (1'b0),
    .rd_addr ({f_r, t_r}),
    .rd_data ()
  );

  assign n_words = ({2'b00, word_count_r} > 9'(MAX_WORDS)) ? 9'(MAX_WORDS)
                                                             : {2'b00, word_count_r};
  assign in_ok = (in_from_word != '0) && ({2'b00, in_from_word} <= n_words) &&
                 (in_to_word != '0) && ({2'b00, in_to_word} <= n_words);

  assign t_bit     = MW'(1) << t_r;
  assign reach_now = reached_r | (rd_pend_r ? adj_rd_row : '0);
  assign pend      = reach_now & ~visited_r;

  always_comb begin
    pick = '0;
    for (int i = MW - 1; i >= 0; i--) begin
      if (pend[i]) begin
        pick = VW'(i);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    f_nxt          = f_r;
    t_nxt          = t_r;
    lab_nxt        = lab_r;
    row_f_nxt      = row_f_r;
    reached_nxt    = reached_r;
    visited_nxt    = visited_r;
    rd_pend_nxt    = 1'b0;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    adj_clr        = 1'b0;
    adj_rd_en      = 1'b0;
    adj_rd_addr    = f_r;
    adj_wr_en      = 1'b0;
    adj_wr_addr    = f_r;
    adj_wr_row     = row_f_r | t_bit;
    lab_we         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt = in_kind;
          f_nxt    = VW'(in_from_word - 7'd1);
          t_nxt    = VW'(in_to_word - 7'd1);
          lab_nxt  = ({3'b000, in_relation} >= 9'(RELATION_COUNT)) ?
                     LW'(RELATION_COUNT - 1) : LW'(in_relation);
          if (in_kind == KIND_CLEAR) begin
            adj_clr        = 1'b1;
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_DONE;
          end else if (!in_ok) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_RANGE;
          end else begin
            adj_rd_en   = 1'b1;
            adj_rd_addr = f_nxt;
            state_nxt   = S_ROWF;
          end
        end
      end
      S_ROWF: begin
        row_f_nxt = adj_rd_row;
        state_nxt = S_IDLE;
        out_valid_nxt = 1'b1;
        out_status_nxt = ST_DONE;
        case (kind_r)
          KIND_INSERT: begin
            if ((f_r == t_r) || adj_rd_row[t_r]) begin
              out_status_nxt = ST_REFUSED;
            end else begin
              out_valid_nxt = 1'b0;
              reached_nxt   = t_bit;
              visited_nxt   = '0;
              state_nxt     = S_SEARCH;
            end
          end
          KIND_REMOVE: begin
            if (!adj_rd_row[t_r]) begin
              out_status_nxt = ST_NO_EDGE;
            end else begin
              adj_wr_en  = 1'b1;
              adj_wr_row = adj_rd_row & ~t_bit;
            end
          end
          default: begin
            if (!adj_rd_row[t_r]) begin
              out_status_nxt = ST_NO_EDGE;
            end else begin
              lab_we = 1'b1;
            end
          end
        endcase
      end
      S_SEARCH: begin
        reached_nxt = reach_now;
        if (reach_now[f_r]) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_REFUSED;
          state_nxt      = S_IDLE;
        end else if (pend == '0) begin
          adj_wr_en      = 1'b1;
          lab_we         = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_DONE;
          state_nxt      = S_IDLE;
        end else begin
          adj_rd_en   = 1'b1;
          adj_rd_addr = pick;
          visited_nxt = visited_r | (MW'(1) << pick);
          rd_pend_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      word_count_r <= WORD_COUNT_RST;
      out_valid_r  <= 1'b0;
      rd_pend_r    <= 1'b0;
      reached_r    <= '0;
      visited_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_pend_r   <= rd_pend_nxt;
      reached_r   <= reached_nxt;
      visited_r   <= visited_nxt;
      if (cfg_we) begin
        word_count_r <= cfg_wdata;
      end
    end
    kind_r       <= kind_nxt;
    f_r          <= f_nxt;
    t_r          <= t_nxt;
    lab_r        <= lab_nxt;
    row_f_r      <= row_f_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

endmodule
`default_nettype wire
